### hdl/ddt_pkg.sv
// Package for the dependency tracker: sizes, codes, request and response types.
`timescale 1ns / 1ps
package ddt_pkg;
   localparam int MaxNodes = 64;
   localparam int SlotW = $clog2(MaxNodes);
   localparam int CntW = $clog2(MaxNodes + 1);
   localparam int EdgeW = 11;

   typedef enum logic [2:0] {
      OP_ADD_NODE = 3'd0, OP_REMOVE_NODE = 3'd1, OP_ADD_EDGE = 3'd2,
      OP_REMOVE_EDGE = 3'd3, OP_HAS_DEP = 3'd4, OP_DEP_COUNT = 3'd5,
      OP_WOULD_CYCLE = 3'd6, OP_UNUSED = 3'd7
   } op_type;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_EXISTS = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_CYCLE = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  key_a_type;
      logic [63:0] key_a_id0;
      logic [63:0] key_a_id1;
      logic [63:0] key_a_id2;
      logic [63:0] key_a_id3;
      logic [7:0]  key_b_type;
      logic [63:0] key_b_id0;
      logic [63:0] key_b_id1;
      logic [63:0] key_b_id2;
      logic [63:0] key_b_id3;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  answer;
      logic [6:0]  node_total;
      logic [10:0] edge_total;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_LOOKUP, S_FETCH, S_DECIDE, S_WALK, S_PRUNE, S_COUNT, S_DONE
   } state_type;
endpackage

### hdl/dag_dependency_tracker.sv
// Dependency graph tracker with a sequenced table scan and reachability walk.
// Sequence: a key sweep over all slots, a row fetch and a decision state, then a prune
// or count sweep, or one sweep per walk level (at most MaxNodes passes).
// The response strobe is registered in the done state.
// Throughput: one request at a time; busy stays high until the strobe, no stall input.
// Synchronous active-high reset clears valid bits, counts and the sequencer.
`timescale 1ns / 1ps
module dag_dependency_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ddt_pkg::req_type  req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output ddt_pkg::rsp_type  rsp_data
);
   import ddt_pkg::*;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [MaxNodes-1:0] valid_ff;
   logic [7:0]          type_mem [MaxNodes];
   logic [255:0]        id_mem [MaxNodes];
   logic [MaxNodes-1:0] child_mem [MaxNodes];
   logic [7:0]          type_rd_ff;
   logic [255:0]        id_rd_ff;
   logic [MaxNodes-1:0] child_rd_ff;
   logic [MaxNodes-1:0] row_a_ff;
   logic [SlotW-1:0]    rd_slot_ff;
   logic [CntW-1:0]     nodes_ff;
   logic [EdgeW-1:0]    edges_ff;
   logic [CntW-1:0]     idx_ff;
   logic [SlotW-1:0]    slot;
   logic                a_hit_ff, b_hit_ff;
   logic [SlotW-1:0]    a_slot_ff, b_slot_ff;
   logic [MaxNodes-1:0] visited_ff, frontier_ff, next_ff;
   logic [6:0]          count_ff;
   logic [2:0]          status_ff;
   logic [5:0]          answer_ff;
   logic                rsp_ff;
   logic                walk_hit;
   logic                key_we;
   logic                row_we;
   logic [SlotW-1:0]    row_waddr;
   logic [MaxNodes-1:0] row_wdata;

   assign slot = idx_ff[SlotW-1:0];
   // Each sweep issues slots 0 to MaxNodes-1 and works on the read data in the cycle after.
   wire sweep_end = (idx_ff == CntW'(MaxNodes));
   wire rd_ok = (idx_ff != '0);
   wire [255:0] key_a = {req_ff.key_a_id3, req_ff.key_a_id2, req_ff.key_a_id1,
                         req_ff.key_a_id0};
   wire [255:0] key_b = {req_ff.key_b_id3, req_ff.key_b_id2, req_ff.key_b_id1,
                         req_ff.key_b_id0};
   wire eq_a = valid_ff[rd_slot_ff] && type_rd_ff == req_ff.key_a_type && id_rd_ff == key_a;
   wire eq_b = valid_ff[rd_slot_ff] && type_rd_ff == req_ff.key_b_type && id_rd_ff == key_b;
   wire keys_same = req_ff.key_a_type == req_ff.key_b_type && key_a == key_b;
   wire [MaxNodes-1:0] row_a = row_a_ff;
   wire [MaxNodes-1:0] a_bit = MaxNodes'(1) << a_slot_ff;
   wire [MaxNodes-1:0] b_bit = MaxNodes'(1) << b_slot_ff;
   wire is_cycle_op = req_ff.operation == OP_ADD_EDGE || req_ff.operation == OP_WOULD_CYCLE;
   wire do_lookup_b = is_cycle_op || req_ff.operation == OP_REMOVE_EDGE;
   wire fold = rd_ok && frontier_ff[rd_slot_ff];
   wire [MaxNodes-1:0] next_full = next_ff | (fold ? child_rd_ff : '0);
   wire add_ok = req_ff.operation == OP_ADD_NODE && !a_hit_ff
                 && nodes_ff < CntW'(MaxNodes);
   wire rm_edge_ok = req_ff.operation == OP_REMOVE_EDGE && a_hit_ff && b_hit_ff
                     && row_a[b_slot_ff];
   wire prune_hit = rd_ok && valid_ff[rd_slot_ff] && child_rd_ff[a_slot_ff];
   wire link_ok = req_ff.operation == OP_ADD_EDGE && status_ff == ST_OK
                  && !visited_ff[a_slot_ff];

   // First free slot, found by priority over the valid bits.
   logic [SlotW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int i = MaxNodes - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_slot = SlotW'(i);
      end
   end

   assign walk_hit = visited_ff[a_slot_ff];
   assign key_we = state_ff == S_DECIDE && add_ok;

   // A child row is cleared when its slot is allocated, so stale rows are never read.
   always_comb begin
      row_we = 1'b0;
      row_waddr = a_slot_ff;
      row_wdata = row_a_ff;
      unique case (state_ff)
         S_DECIDE: begin
            if (add_ok) begin
               row_we = 1'b1;
               row_waddr = free_slot;
               row_wdata = '0;
            end else if (rm_edge_ok) begin
               row_we = 1'b1;
               row_wdata = row_a_ff & ~b_bit;
            end
         end
         S_PRUNE: begin
            if (prune_hit) begin
               row_we = 1'b1;
               row_waddr = rd_slot_ff;
               row_wdata = child_rd_ff & ~a_bit;
            end
         end
         S_DONE: begin
            if (link_ok) begin
               row_we = 1'b1;
               row_wdata = row_a_ff | b_bit;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         type_mem[free_slot] <= req_ff.key_a_type;
         id_mem[free_slot] <= key_a;
      end
      type_rd_ff <= type_mem[slot];
      id_rd_ff <= id_mem[slot];
      rd_slot_ff <= slot;
   end

   always_ff @(posedge clock) begin
      if (row_we) child_mem[row_waddr] <= row_wdata;
      child_rd_ff <= child_mem[slot];
      if (state_ff == S_FETCH) row_a_ff <= child_mem[a_slot_ff];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_LOOKUP;
         S_LOOKUP: if (sweep_end) state_in = S_FETCH;
         S_FETCH:  state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_DONE;
            unique case (op_type'(req_ff.operation))
               OP_REMOVE_NODE:
                  if (a_hit_ff && row_a == '0) state_in = S_PRUNE;
               OP_ADD_EDGE:
                  if (a_hit_ff && b_hit_ff && !row_a[b_slot_ff] && a_slot_ff != b_slot_ff)
                     state_in = S_WALK;
               OP_WOULD_CYCLE:
                  if (!keys_same && a_hit_ff && b_hit_ff) state_in = S_WALK;
               OP_HAS_DEP, OP_DEP_COUNT: if (a_hit_ff) state_in = S_COUNT;
               default: state_in = S_DONE;
            endcase
         end
         S_WALK:
            if (sweep_end && (walk_hit || (next_full & ~visited_ff) == '0))
               state_in = S_DONE;
         S_PRUNE: if (sweep_end) state_in = S_DONE;
         S_COUNT: if (sweep_end) state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy = state_ff != S_IDLE;
      rsp_strobe = rsp_ff;
      rsp_data.status = status_ff;
      rsp_data.answer = answer_ff;
      rsp_data.node_total = 7'(nodes_ff);
      rsp_data.edge_total = edges_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         nodes_ff <= '0;
         edges_ff <= '0;
         rsp_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               req_ff <= req_data;
               idx_ff <= '0;
               a_hit_ff <= 1'b0;
               b_hit_ff <= 1'b0;
               count_ff <= '0;
               status_ff <= ST_OK;
               answer_ff <= '0;
            end
            S_LOOKUP: begin
               if (rd_ok && eq_a && !a_hit_ff) begin
                  a_hit_ff <= 1'b1;
                  a_slot_ff <= rd_slot_ff;
               end
               if (rd_ok && do_lookup_b && eq_b && !b_hit_ff) begin
                  b_hit_ff <= 1'b1;
                  b_slot_ff <= rd_slot_ff;
               end
               idx_ff <= sweep_end ? '0 : idx_ff + 1'b1;
            end
            S_DECIDE: begin
               visited_ff <= b_bit;
               frontier_ff <= b_bit;
               next_ff <= '0;
               unique case (op_type'(req_ff.operation))
                  OP_ADD_NODE: begin
                     if (a_hit_ff) status_ff <= ST_EXISTS;
                     else if (nodes_ff >= CntW'(MaxNodes)) status_ff <= ST_FULL;
                     else begin
                        valid_ff[free_slot] <= 1'b1;
                        nodes_ff <= nodes_ff + 1'b1;
                     end
                  end
                  OP_REMOVE_NODE: begin
                     if (!a_hit_ff) status_ff <= ST_NOT_FOUND;
                     else if (row_a != '0) status_ff <= ST_EXISTS;
                     else begin
                        valid_ff[a_slot_ff] <= 1'b0;
                        nodes_ff <= nodes_ff - 1'b1;
                     end
                  end
                  OP_ADD_EDGE: begin
                     if (!a_hit_ff || !b_hit_ff) status_ff <= ST_NOT_FOUND;
                     else if (row_a[b_slot_ff]) status_ff <= ST_EXISTS;
                     else if (a_slot_ff == b_slot_ff) status_ff <= ST_CYCLE;
                  end
                  OP_REMOVE_EDGE: begin
                     if (!rm_edge_ok) status_ff <= ST_NOT_FOUND;
                     else edges_ff <= edges_ff - 1'b1;
                  end
                  OP_WOULD_CYCLE: if (keys_same) answer_ff <= 6'd1;
                  default: ;
               endcase
            end
            S_WALK: begin
               // One pass over the frontier per sweep; the next set folds child rows.
               idx_ff <= sweep_end ? '0 : idx_ff + 1'b1;
               if (sweep_end) begin
                  frontier_ff <= next_full & ~visited_ff;
                  visited_ff <= visited_ff | next_full;
                  next_ff <= '0;
               end else begin
                  next_ff <= next_full;
               end
            end
            S_PRUNE: begin
               if (prune_hit) edges_ff <= edges_ff - 1'b1;
               idx_ff <= sweep_end ? '0 : idx_ff + 1'b1;
            end
            S_COUNT: begin
               if (rd_ok) count_ff <= count_ff + 7'(row_a[rd_slot_ff]);
               idx_ff <= sweep_end ? '0 : idx_ff + 1'b1;
            end
            S_DONE: begin
               rsp_ff <= 1'b1;
               if (req_ff.operation == OP_HAS_DEP) answer_ff <= 6'(count_ff != '0);
               if (req_ff.operation == OP_DEP_COUNT)
                  answer_ff <= count_ff > 7'd63 ? 6'd63 : count_ff[5:0];
               if (is_cycle_op && status_ff == ST_OK && !keys_same && a_hit_ff && b_hit_ff
                   && visited_ff[a_slot_ff]) begin
                  if (req_ff.operation == OP_WOULD_CYCLE) answer_ff <= 6'd1;
                  else status_ff <= ST_CYCLE;
               end else if (link_ok) begin
                  edges_ff <= edges_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // The visited set only grows during a walk, so the decision is final once set.
   // The response fields are registered in the done state; they show in the cycle after.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_DONE)
      else $error("response without done state");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held");
   assert property (@(posedge clock) disable iff (reset)
      nodes_ff <= CntW'(MaxNodes))
      else $error("node count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && idx_ff != '0) |-> $stable(visited_ff))
      else $error("visited set changed mid pass");
endmodule
